@@ hw/rtl/sgr_attribute_parser_defines.svh @@
// Assertion macros for the SGR attribute parser.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef SGR_ATTRIBUTE_PARSER_DEFINES_SVH
`define SGR_ATTRIBUTE_PARSER_DEFINES_SVH

// Condition that holds in every cycle out of reset.
`define SGR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SGR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sgr_pkg.sv @@
// Package for the SGR attribute parser: parse phase and color target types,
// rendition codes and color type tags. No dependencies.
package sgr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_UL_SUB = 3'd1,
        PH_CTYPE  = 3'd2,
        PH_INDEX  = 3'd3,
        PH_SPACE  = 3'd4,
        PH_RED    = 3'd5,
        PH_GREEN  = 3'd6,
        PH_BLUE   = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        TGT_FORE  = 2'd0,
        TGT_BACK  = 2'd1,
        TGT_UNDER = 2'd2
    } t_target;

    // Fixed rendition codes.
    localparam logic [15:0] C_RESET       = 16'd0;
    localparam logic [15:0] C_BOLD        = 16'd1;
    localparam logic [15:0] C_DIM         = 16'd2;
    localparam logic [15:0] C_ITALIC      = 16'd3;
    localparam logic [15:0] C_UNDERLINE   = 16'd4;
    localparam logic [15:0] C_REVERSE     = 16'd7;
    localparam logic [15:0] C_STRIKE      = 16'd9;
    localparam logic [15:0] C_DBL_UNDER   = 16'd21;
    localparam logic [15:0] C_BOLD_OFF    = 16'd221;
    localparam logic [15:0] C_DIM_OFF     = 16'd222;
    localparam logic [15:0] C_NORMAL      = 16'd22;
    localparam logic [15:0] C_ITALIC_OFF  = 16'd23;
    localparam logic [15:0] C_UNDER_OFF   = 16'd24;
    localparam logic [15:0] C_REVERSE_OFF = 16'd27;
    localparam logic [15:0] C_STRIKE_OFF  = 16'd29;
    localparam logic [15:0] C_FG_FIRST    = 16'd30;
    localparam logic [15:0] C_FG_LAST     = 16'd37;
    localparam logic [15:0] C_FG_EXT      = 16'd38;
    localparam logic [15:0] C_FG_DEFAULT  = 16'd39;
    localparam logic [15:0] C_BG_FIRST    = 16'd40;
    localparam logic [15:0] C_BG_LAST     = 16'd47;
    localparam logic [15:0] C_BG_EXT      = 16'd48;
    localparam logic [15:0] C_BG_DEFAULT  = 16'd49;
    localparam logic [15:0] C_FGB_FIRST   = 16'd90;
    localparam logic [15:0] C_FGB_LAST    = 16'd97;
    localparam logic [15:0] C_BGB_FIRST   = 16'd100;
    localparam logic [15:0] C_BGB_LAST    = 16'd107;
    localparam logic [15:0] C_BRIGHT_OFS  = 16'd8;

    // Color type sub-parameters.
    localparam logic [15:0] CT_RGB        = 16'd2;
    localparam logic [15:0] CT_INDEXED    = 16'd5;

    // Low byte tags of a stored color.
    localparam logic [7:0]  TAG_INDEXED   = 8'h01;
    localparam logic [7:0]  TAG_RGB       = 8'h02;

    localparam logic [2:0]  UL_SINGLE     = 3'd1;
    localparam logic [2:0]  UL_DOUBLE     = 3'd2;
    localparam logic [2:0]  UL_MAX        = 3'd5;

    localparam logic [15:0] CFG_UL_CODE_RESET = 16'd58;

endpackage

@@ hw/rtl/sgr_attribute_parser.sv @@
// SGR attribute parser top level: decodes one rendition parameter per request
// and reports the full attribute set. Depends on sgr_pkg and the defines header.
//
// Channel   Dir  Signals                               Payload
// s_axis    in   tvalid tready tdata[23:0] tuser[0:0]  param, params_after, group_mode
// m_axis    out  tvalid tready tdata[103:0]            attributes after the request
// cfg       in   i_cfg_we i_cfg_wdata[15:0]            underline color code
//
// A request is registered at the input and then decoded into the output
// register, which holds the result; one request per cycle is sustained
// while the output is not stalled, because each request needs a single
// state update.
// Reset is synchronous and active low; it clears the attributes, the parse
// phase and the configured code back to 58. A stalled output holds the
// pipeline and drops s_axis_tready in the same cycle while the input register is full.
`include "sgr_attribute_parser_defines.svh"

module sgr_attribute_parser #(
    parameter int unsigned MAX_PARAMS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [15:0] param, [23:16] params_after
    input  logic [23:0]   s_axis_tdata,
    // [0] group_mode
    input  logic [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [0] bold, [1] dim, [2] italic, [3] reverse_video, [4] strike,
    // [7:5] underline_style, [39:8] fore_color, [71:40] back_color,
    // [103:72] underline_color
    output logic [103:0]  m_axis_tdata
);

    localparam int unsigned AfterCap = MAX_PARAMS - 1;

    logic [15:0]      r_ul_code;

    logic             r_in_valid;
    logic [15:0]      r_in_param;
    logic [7:0]       r_in_after;
    logic             r_in_grp;

    logic             r_out_valid;
    logic [103:0]     r_out_data;

    logic             r_bold, n_bold;
    logic             r_dim, n_dim;
    logic             r_italic, n_italic;
    logic             r_reverse, n_reverse;
    logic             r_strike, n_strike;
    logic [2:0]       r_ul_kind, n_ul_kind;
    logic [31:0]      r_fore, n_fore;
    logic [31:0]      r_back, n_back;
    logic [31:0]      r_ul_color, n_ul_color;
    sgr_pkg::t_phase  r_phase, n_phase;
    sgr_pkg::t_target r_target, n_target;
    logic [15:0]      r_hold, n_hold;
    logic             r_skip, n_skip;

    logic             out_free;
    logic             fire;
    logic [7:0]       after;
    logic             fin;
    logic             put;
    logic [31:0]      put_val;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ul_code <= sgr_pkg::CFG_UL_CODE_RESET;
        end else if (i_cfg_we) begin
            r_ul_code <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_param <= s_axis_tdata[15:0];
            r_in_after <= s_axis_tdata[23:16];
            r_in_grp   <= s_axis_tuser[0];
        end
    end

    // Parse state and attribute registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bold     <= 1'b0;
            r_dim      <= 1'b0;
            r_italic   <= 1'b0;
            r_reverse  <= 1'b0;
            r_strike   <= 1'b0;
            r_ul_kind  <= 3'd0;
            r_fore     <= 32'd0;
            r_back     <= 32'd0;
            r_ul_color <= 32'd0;
            r_phase    <= sgr_pkg::PH_IDLE;
            r_target   <= sgr_pkg::TGT_FORE;
            r_hold     <= 16'd0;
            r_skip     <= 1'b0;
        end else if (fire) begin
            r_bold     <= n_bold;
            r_dim      <= n_dim;
            r_italic   <= n_italic;
            r_reverse  <= n_reverse;
            r_strike   <= n_strike;
            r_ul_kind  <= n_ul_kind;
            r_fore     <= n_fore;
            r_back     <= n_back;
            r_ul_color <= n_ul_color;
            r_phase    <= n_phase;
            r_target   <= n_target;
            r_hold     <= n_hold;
            r_skip     <= n_skip;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {n_ul_color, n_back, n_fore, n_ul_kind,
                           n_strike, n_reverse, n_italic, n_dim, n_bold};
        end
    end

    always_comb begin
        if (32'(r_in_after) > AfterCap) begin
            after = 8'(AfterCap);
        end else begin
            after = r_in_after;
        end
    end

    always_comb begin
        n_bold     = r_bold;
        n_dim      = r_dim;
        n_italic   = r_italic;
        n_reverse  = r_reverse;
        n_strike   = r_strike;
        n_ul_kind  = r_ul_kind;
        n_fore     = r_fore;
        n_back     = r_back;
        n_ul_color = r_ul_color;
        n_phase    = r_phase;
        n_target   = r_target;
        n_hold     = r_hold;
        n_skip     = r_skip;
        fin        = 1'b0;
        put        = 1'b0;
        put_val    = 32'd0;

        if (!r_skip) begin
            unique case (r_phase)
                sgr_pkg::PH_IDLE: begin
                    fin = 1'b1;
                    priority if (r_in_param == sgr_pkg::C_RESET) begin
                        n_bold     = 1'b0;
                        n_dim      = 1'b0;
                        n_italic   = 1'b0;
                        n_reverse  = 1'b0;
                        n_strike   = 1'b0;
                        n_ul_kind  = 3'd0;
                        n_fore     = 32'd0;
                        n_back     = 32'd0;
                        n_ul_color = 32'd0;
                    end else if (r_in_param == sgr_pkg::C_BOLD) begin
                        n_bold = 1'b1;
                    end else if (r_in_param == sgr_pkg::C_DIM) begin
                        n_dim = 1'b1;
                    end else if (r_in_param == sgr_pkg::C_ITALIC) begin
                        n_italic = 1'b1;
                    end else if (r_in_param == sgr_pkg::C_UNDERLINE) begin
                        if (r_in_grp && after != 8'd0) begin
                            n_phase = sgr_pkg::PH_UL_SUB;
                            fin     = 1'b0;
                        end else begin
                            n_ul_kind = sgr_pkg::UL_SINGLE;
                        end
                    end else if (r_in_param == sgr_pkg::C_REVERSE) begin
                        n_reverse = 1'b1;
                    end else if (r_in_param == sgr_pkg::C_STRIKE) begin
                        n_strike = 1'b1;
                    end else if (r_in_param == sgr_pkg::C_DBL_UNDER) begin
                        n_ul_kind = sgr_pkg::UL_DOUBLE;
                    end else if (r_in_param == sgr_pkg::C_BOLD_OFF) begin
                        n_bold = 1'b0;
                    end else if (r_in_param == sgr_pkg::C_DIM_OFF) begin
                        n_dim = 1'b0;
                    end else if (r_in_param == sgr_pkg::C_NORMAL) begin
                        n_bold = 1'b0;
                        n_dim  = 1'b0;
                    end else if (r_in_param == sgr_pkg::C_ITALIC_OFF) begin
                        n_italic = 1'b0;
                    end else if (r_in_param == sgr_pkg::C_UNDER_OFF) begin
                        n_ul_kind = 3'd0;
                    end else if (r_in_param == sgr_pkg::C_REVERSE_OFF) begin
                        n_reverse = 1'b0;
                    end else if (r_in_param == sgr_pkg::C_STRIKE_OFF) begin
                        n_strike = 1'b0;
                    end else if (r_in_param >= sgr_pkg::C_FG_FIRST &&
                                 r_in_param <= sgr_pkg::C_FG_LAST) begin
                        n_fore = {16'd0, 8'(r_in_param - sgr_pkg::C_FG_FIRST),
                                  sgr_pkg::TAG_INDEXED};
                    end else if (r_in_param == sgr_pkg::C_FG_EXT) begin
                        if (after != 8'd0) begin
                            n_target = sgr_pkg::TGT_FORE;
                            n_phase  = sgr_pkg::PH_CTYPE;
                            fin      = 1'b0;
                        end
                    end else if (r_in_param == sgr_pkg::C_FG_DEFAULT) begin
                        n_fore = 32'd0;
                    end else if (r_in_param >= sgr_pkg::C_BG_FIRST &&
                                 r_in_param <= sgr_pkg::C_BG_LAST) begin
                        n_back = {16'd0, 8'(r_in_param - sgr_pkg::C_BG_FIRST),
                                  sgr_pkg::TAG_INDEXED};
                    end else if (r_in_param == sgr_pkg::C_BG_EXT) begin
                        if (after != 8'd0) begin
                            n_target = sgr_pkg::TGT_BACK;
                            n_phase  = sgr_pkg::PH_CTYPE;
                            fin      = 1'b0;
                        end
                    end else if (r_in_param == sgr_pkg::C_BG_DEFAULT) begin
                        n_back = 32'd0;
                    end else if (r_in_param >= sgr_pkg::C_FGB_FIRST &&
                                 r_in_param <= sgr_pkg::C_FGB_LAST) begin
                        n_fore = {16'd0, 8'(r_in_param - sgr_pkg::C_FGB_FIRST +
                                            sgr_pkg::C_BRIGHT_OFS),
                                  sgr_pkg::TAG_INDEXED};
                    end else if (r_in_param >= sgr_pkg::C_BGB_FIRST &&
                                 r_in_param <= sgr_pkg::C_BGB_LAST) begin
                        n_back = {16'd0, 8'(r_in_param - sgr_pkg::C_BGB_FIRST +
                                            sgr_pkg::C_BRIGHT_OFS),
                                  sgr_pkg::TAG_INDEXED};
                    end else if (r_in_param == r_ul_code) begin
                        if (after != 8'd0) begin
                            n_target = sgr_pkg::TGT_UNDER;
                            n_phase  = sgr_pkg::PH_CTYPE;
                            fin      = 1'b0;
                        end
                    end else if ({1'b0, r_in_param} == {1'b0, r_ul_code} + 17'd1) begin
                        // Compared at 17 bits so that code 65535 has no reset code.
                        n_ul_color = 32'd0;
                    end else begin
                        // Unknown codes change nothing.
                        n_ul_color = r_ul_color;
                    end
                end
                sgr_pkg::PH_UL_SUB: begin
                    n_ul_kind = (r_in_param < 16'(sgr_pkg::UL_MAX)) ? r_in_param[2:0]
                                                                     : sgr_pkg::UL_MAX;
                    fin = 1'b1;
                end
                sgr_pkg::PH_CTYPE: begin
                    if (r_in_param == sgr_pkg::CT_INDEXED && after != 8'd0) begin
                        n_phase = sgr_pkg::PH_INDEX;
                    end else if (r_in_param == sgr_pkg::CT_RGB && after >= 8'd4) begin
                        // A leading color-space parameter is skipped.
                        n_phase = sgr_pkg::PH_SPACE;
                    end else if (r_in_param == sgr_pkg::CT_RGB && after >= 8'd3) begin
                        n_phase = sgr_pkg::PH_RED;
                    end else begin
                        fin = 1'b1;
                    end
                end
                sgr_pkg::PH_INDEX: begin
                    put     = 1'b1;
                    put_val = {16'd0, r_in_param[7:0], sgr_pkg::TAG_INDEXED};
                    fin     = 1'b1;
                end
                sgr_pkg::PH_SPACE: begin
                    n_phase = sgr_pkg::PH_RED;
                end
                sgr_pkg::PH_RED: begin
                    n_hold  = {r_in_param[7:0], 8'h00};
                    n_phase = sgr_pkg::PH_GREEN;
                end
                sgr_pkg::PH_GREEN: begin
                    n_hold  = {r_hold[15:8], r_in_param[7:0]};
                    n_phase = sgr_pkg::PH_BLUE;
                end
                sgr_pkg::PH_BLUE: begin
                    put     = 1'b1;
                    put_val = {r_hold[15:8], r_hold[7:0], r_in_param[7:0],
                               sgr_pkg::TAG_RGB};
                    fin     = 1'b1;
                end
            endcase
        end

        if (put) begin
            unique case (r_target)
                sgr_pkg::TGT_FORE:  n_fore     = put_val;
                sgr_pkg::TGT_BACK:  n_back     = put_val;
                sgr_pkg::TGT_UNDER: n_ul_color = put_val;
                default:            n_fore     = r_fore;
            endcase
        end

        // A completed attribute in a group sequence mutes the rest of it.
        if (fin) begin
            n_phase = sgr_pkg::PH_IDLE;
            if (r_in_grp && after != 8'd0) begin
                n_skip = 1'b1;
            end
        end

        // The last parameter always ends the sequence.
        if (after == 8'd0) begin
            n_phase = sgr_pkg::PH_IDLE;
            n_skip  = 1'b0;
        end
    end

    `SGR_ASSERT_SAME(a_skip_idle, r_skip, r_phase == sgr_pkg::PH_IDLE,
        "skipping while a parse is in progress")
    `SGR_ASSERT_ALWAYS(a_ul_range, r_ul_kind <= sgr_pkg::UL_MAX,
        "underline style out of range")
    `SGR_ASSERT_NEXT(a_last_ends, fire && r_in_after == 8'd0,
        r_phase == sgr_pkg::PH_IDLE && !r_skip,
        "last parameter did not end the sequence")
    `SGR_ASSERT_ALWAYS(a_fore_tag, r_fore == 32'd0 ||
        r_fore[7:0] == sgr_pkg::TAG_INDEXED || r_fore[7:0] == sgr_pkg::TAG_RGB,
        "foreground color has a bad tag")
    `SGR_ASSERT_SAME(a_out_source, $rose(r_out_valid), $past(fire),
        "result appeared without a decoded request")

endmodule
